[sv/spp_pkg.sv]
// Shared constants, register codes and status types of the sine plasma pixel generator.
// Depends on nothing; every other file of the block imports it.
package spp_pkg;

	// Field widths of the channels.
	localparam int PX_W        = 9;
	localparam int PY_W        = 8;
	localparam int STEP_W      = 5;
	localparam int COLOR_W     = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 9;

	// Default geometry and sine resolution.
	localparam int WIDTH_DEF      = 320;
	localparam int HEIGHT_DEF     = 200;
	localparam int SINE_STEPS_DEF = 1024;

	// Fixed-point constants of the distance and phase arithmetic.
	localparam int DIST_W      = 16;
	localparam int DIST_FRAC2  = 12;
	localparam int SINE_W      = 16;
	localparam int DIV_ONE     = 10;
	localparam int DIV_TWO     = 7;
	localparam int AMP_ONE     = 100;
	localparam int AMP_TWO     = 150;
	localparam int FOLD_BASE   = 512;
	localparam int FOLD_LIMIT  = 255;
	localparam int COLOR_SUB   = 254;
	localparam int SUM_SHIFT   = 14;
	localparam int PHASE_LAT   = 7;
	localparam longint unsigned TWO_PI_Q16  = 64'd411775;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Reset values of the configuration registers.
	localparam logic signed [STEP_W-1:0] STEP_X_ONE_RST = 5'sd2;
	localparam logic signed [STEP_W-1:0] STEP_Y_ONE_RST = -5'sd2;
	localparam logic signed [STEP_W-1:0] STEP_X_TWO_RST = -5'sd3;
	localparam logic signed [STEP_W-1:0] STEP_Y_TWO_RST = 5'sd4;
	localparam int START_X_ONE_RST = 100;
	localparam int START_Y_ONE_RST = 100;
	localparam int START_X_TWO_RST = 42;
	localparam int START_Y_TWO_RST = 170;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QCNT_W = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_X_ONE  = 4'd0,
		REG_STEP_Y_ONE  = 4'd1,
		REG_STEP_X_TWO  = 4'd2,
		REG_STEP_Y_TWO  = 4'd3,
		REG_START_X_ONE = 4'd4,
		REG_START_Y_ONE = 4'd5,
		REG_START_X_TWO = 4'd6,
		REG_START_Y_TWO = 4'd7
	} cfg_reg_e;

	// Status of the queue, watched by the top level.
	typedef struct packed {
		logic              push;
		logic              pop;
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

endpackage

[sv/spp_if.sv]
// Handshake interfaces of the pixel, color and configuration channels.
// Depends on spp_pkg for the field widths.
interface spp_pixel_if import spp_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PX_W-1:0] pixel_x;
	logic [PY_W-1:0] pixel_y;
	logic            frame_start;
	modport source (output valid, pixel_x, pixel_y, frame_start, input ready);
	modport sink (input valid, pixel_x, pixel_y, frame_start, output ready);
endinterface

interface spp_color_if import spp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] color_index;
	modport source (output valid, color_index, input ready);
	modport sink (input valid, color_index, output ready);
endinterface

interface spp_cfg_if import spp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/sine_plasma_pixel_generator.sv]
// Top level of the sine plasma pixel generator: front, queue and back.
// Depends on spp_pkg, spp_if, spp_front, spp_queue and spp_back.
//
//   channel  role   carries                              handshake
//   pix      sink   pixel_x, pixel_y, frame_start        valid / ready
//   color    source color_index                          valid / ready
//   cfg      sink   index, data (register write)         valid / ready, ready always high
//
// One pixel per clock is accepted and one color per clock is delivered while color.ready
// stays high. A pixel passes the queue entry, written at the accepting edge, the squares
// stage, MW+7 square root stages, seven phase stages, one weight stage and the output
// register. Reset loads the origins and velocities from the register defaults; there
// is no clearing pass. A stalled output freezes the whole back pipeline; the four-entry
// queue then fills and pix.ready falls.
module sine_plasma_pixel_generator import spp_pkg::*; #(
	parameter int WIDTH      = WIDTH_DEF,
	parameter int HEIGHT     = HEIGHT_DEF,
	parameter int SINE_STEPS = SINE_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	spp_pixel_if.sink   pix,
	spp_color_if.source color,
	spp_cfg_if.sink     cfg
);
	localparam int XW = ($clog2(WIDTH) > PX_W) ? $clog2(WIDTH) : PX_W;
	localparam int MW = ($clog2(HEIGHT) > XW) ? $clog2(HEIGHT) : XW;

	logic            push;
	logic [4*MW-1:0] push_data;
	logic [4*MW-1:0] head_data;
	logic            pop;
	queue_stat_t     qstat;

	spp_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT), .MW(MW)) u_front (
		.clk(clk), .arst_n(arst_n), .pix(pix), .cfg(cfg),
		.q_full(qstat.full), .push(push), .push_data(push_data)
	);

	spp_queue #(.DATA_W(4 * MW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head_data(head_data), .stat(qstat)
	);

	spp_back #(.MW(MW), .SINE_STEPS(SINE_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(!qstat.empty), .q_data(head_data),
		.pop(pop), .color(color)
	);

`ifndef ASSERT_OFF
	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		color.valid |-> (color.color_index != 8'd0 && color.color_index != 8'd255))
		else $error("color index at a reserved palette end");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QDEPTH))
		else $error("queue fill count beyond its depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.pop |-> !qstat.empty)
		else $error("queue popped while empty");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.push && !qstat.pop) |=> qstat.count == $past(qstat.count) + QCNT_W'(1))
		else $error("queue count missed a push");
`endif
endmodule

[sv/spp_queue.sv]
// Short queue that decouples the front from the back of the pixel generator.
// Depends on spp_pkg for the depth and the status struct.
module spp_queue import spp_pkg::*; #(
	parameter int DATA_W = 36
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] head_data,
	output queue_stat_t       stat
);
	localparam int QA_W = $clog2(QDEPTH);

	logic [DATA_W-1:0] mem_q [QDEPTH];
	logic [QA_W-1:0]   wr_ptr_q;
	logic [QA_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// Storage is written at the tail; the head is read in place.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_comb begin
		stat.push  = push;
		stat.pop   = pop;
		stat.full  = (cnt_q == QCNT_W'(QDEPTH));
		stat.empty = (cnt_q == '0);
		stat.count = cnt_q;
	end
endmodule

[sv/spp_front.sv]
// Front of the pixel generator: takes pixels and configuration, moves the origins,
// and queues the absolute coordinate differences. Depends on spp_pkg and spp_if.
module spp_front import spp_pkg::*; #(
	parameter int WIDTH  = WIDTH_DEF,
	parameter int HEIGHT = HEIGHT_DEF,
	parameter int MW     = PX_W
) (
	input  logic          clk,
	input  logic          arst_n,
	spp_pixel_if.sink     pix,
	spp_cfg_if.sink       cfg,
	input  logic          q_full,
	output logic          push,
	output logic [4*MW-1:0] push_data
);
	localparam int PW = MW + 2;
	localparam logic [MW-1:0] LIM_X = MW'(WIDTH - 1);
	localparam logic [MW-1:0] LIM_Y = MW'(HEIGHT - 1);

	logic [MW-1:0]            col1_q, row1_q, col2_q, row2_q;
	logic signed [STEP_W-1:0] vx1_q, vy1_q, vx2_q, vy2_q;
	logic [STEP_W+MW-1:0]     nc1, nr1, nc2, nr2;
	logic [MW-1:0]            px, py;

	// Advance one coordinate and reflect its velocity at the screen edges.
	function automatic logic [STEP_W+MW-1:0] bounce(input logic [MW-1:0] pos,
			input logic signed [STEP_W-1:0] vel, input logic [MW-1:0] limit);
		logic signed [PW-1:0]     p;
		logic signed [STEP_W-1:0] v;
		v = vel;
		p = $signed({2'b00, pos}) + PW'(vel);
		if (p > $signed({2'b00, limit})) begin
			v = -v;
			p = $signed({2'b00, limit});
		end
		if (p < PW'(1)) begin
			v = -v;
			p = PW'(1);
		end
		return {v, p[MW-1:0]};
	endfunction

	function automatic logic [MW-1:0] absdiff(input logic [MW-1:0] a, input logic [MW-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// Origins as they stand for this pixel, advanced first on a frame start.
	always_comb begin
		if (pix.frame_start) begin
			nc1 = bounce(col1_q, vx1_q, LIM_X);
			nr1 = bounce(row1_q, vy1_q, LIM_Y);
			nc2 = bounce(col2_q, vx2_q, LIM_X);
			nr2 = bounce(row2_q, vy2_q, LIM_Y);
		end else begin
			nc1 = {vx1_q, col1_q};
			nr1 = {vy1_q, row1_q};
			nc2 = {vx2_q, col2_q};
			nr2 = {vy2_q, row2_q};
		end
	end

	assign px        = MW'(pix.pixel_x);
	assign py        = MW'(pix.pixel_y);
	assign pix.ready = !q_full;
	assign push      = pix.valid && !q_full;
	assign push_data = {absdiff(px, nc1[MW-1:0]), absdiff(py, nr1[MW-1:0]),
		absdiff(px, nc2[MW-1:0]), absdiff(py, nr2[MW-1:0])};
	assign cfg.ready = 1'b1;

	// Origin and velocity state: loaded by configuration, moved by frame starts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx1_q  <= STEP_X_ONE_RST;
			vy1_q  <= STEP_Y_ONE_RST;
			vx2_q  <= STEP_X_TWO_RST;
			vy2_q  <= STEP_Y_TWO_RST;
			col1_q <= MW'(START_X_ONE_RST);
			row1_q <= MW'(START_Y_ONE_RST);
			col2_q <= MW'(START_X_TWO_RST);
			row2_q <= MW'(START_Y_TWO_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STEP_X_ONE:  vx1_q  <= cfg.data[STEP_W-1:0];
				REG_STEP_Y_ONE:  vy1_q  <= cfg.data[STEP_W-1:0];
				REG_STEP_X_TWO:  vx2_q  <= cfg.data[STEP_W-1:0];
				REG_STEP_Y_TWO:  vy2_q  <= cfg.data[STEP_W-1:0];
				REG_START_X_ONE: col1_q <= MW'(cfg.data[PX_W-1:0]);
				REG_START_Y_ONE: row1_q <= MW'(cfg.data[PY_W-1:0]);
				REG_START_X_TWO: col2_q <= MW'(cfg.data[PX_W-1:0]);
				REG_START_Y_TWO: row2_q <= MW'(cfg.data[PY_W-1:0]);
				default: ;
			endcase
		end else if (push && pix.frame_start) begin
			{vx1_q, col1_q} <= nc1;
			{vy1_q, row1_q} <= nr1;
			{vx2_q, col2_q} <= nc2;
			{vy2_q, row2_q} <= nr2;
		end
	end
endmodule

[sv/spp_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on spp_pkg only by convention; no shared types are used.
module spp_isqrt import spp_pkg::*; #(
	parameter int K = 16
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*K-1:0] rad,
	output logic [K-1:0]   root
);
	logic [K+1:0]   rem_s  [K];
	logic [K-1:0]   root_s [K];
	logic [2*K-1:0] rad_s  [K];

	for (genvar i = 0; i < K; i++) begin : g_stage
		logic [K+1:0]   rem_in;
		logic [K-1:0]   root_in;
		logic [2*K-1:0] rad_in;
		logic [K+3:0]   rem2;
		logic [K+3:0]   trial;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign rad_in  = rad_s[i-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		assign rem2  = {rem_in, rad_in[2*K-1 -: 2]};
		assign trial = (K+4)'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i] <= rad_in << 2;
				if (rem2 >= trial) begin
					rem_s[i]  <= (K+2)'(rem2 - trial);
					root_s[i] <= {root_in[K-2:0], 1'b1};
				end else begin
					rem_s[i]  <= (K+2)'(rem2);
					root_s[i] <= {root_in[K-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[K-1];
endmodule

[sv/spp_phase.sv]
// Distance to sine lane: scales a 10.6 distance to a table phase and reads the sine ROM.
// Depends on spp_pkg for the fixed-point constants.
module spp_phase import spp_pkg::*; #(
	parameter int DIV        = DIV_ONE,
	parameter int SINE_STEPS = SINE_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [DIST_W-1:0]        dist_in,
	output logic signed [SINE_W-1:0] sine
);
	localparam int Q_SHIFT = 17;
	localparam int W_SHIFT = 20;
	localparam longint unsigned C_L    = 64'd64 * longint'(DIV) * TWO_PI_Q16;
	localparam longint unsigned K_L    = longint'(SINE_STEPS) * 64'd65536;
	localparam longint unsigned M_L    = ((64'd1 << Q_SHIFT) * K_L) / C_L;
	localparam longint unsigned QMAX_L = (64'd65535 * K_L) / C_L + 64'd1;
	localparam longint unsigned MS_L   = (64'd1 << W_SHIFT) / longint'(SINE_STEPS);
	localparam int M_W   = $clog2(M_L + 1);
	localparam int K_W   = $clog2(K_L + 1);
	localparam int C_W   = $clog2(C_L + 1);
	localparam int Q_W   = $clog2(QMAX_L + 1);
	localparam int MS_W  = $clog2(MS_L + 1);
	localparam int W_W   = $clog2(QMAX_L / longint'(SINE_STEPS) + 2);
	localparam int SS_W  = $clog2(SINE_STEPS + 1);
	localparam int IDX_W = $clog2(SINE_STEPS);
	localparam int P_W   = DIST_W + M_W;
	localparam int T_W   = ((DIST_W + K_W) > (Q_W + C_W) ? (DIST_W + K_W) : (Q_W + C_W)) + 1;
	localparam logic [M_W-1:0]  M_C  = M_W'(M_L);
	localparam logic [K_W-1:0]  K_C  = K_W'(K_L);
	localparam logic [C_W-1:0]  C_C  = C_W'(C_L);
	localparam logic [MS_W-1:0] MS_C = MS_W'(MS_L);
	localparam logic [SS_W-1:0] SS_C = SS_W'(SINE_STEPS);

	typedef logic signed [SINE_W-1:0] rom_t [SINE_STEPS];

	// Quarter-wave Taylor series in Q30, rounded to Q1.14, over one full turn.
	function automatic rom_t build_rom();
		rom_t                r;
		longint unsigned     f, q, u, x, x2, term;
		longint              sum;
		for (int k = 0; k < SINE_STEPS; k++) begin
			f = (longint'(k) << 32) / SINE_STEPS;
			q = (f >> 30) & 64'd3;
			u = f & ((64'd1 << 30) - 64'd1);
			if (q[0]) begin
				u = (64'd1 << 30) - u;
			end
			x    = (u * HALF_PI_Q30) >> 30;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			// Alternating odd terms from x^3/3! up to x^15/15!.
			term = ((term * x2) >> 30) / 64'd6;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd20;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd42;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd72;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd110;
			sum  = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd156;
			sum  = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd210;
			sum  = sum - longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 32768) >>> 16;
			r[k] = (q >= 64'd2) ? SINE_W'(-sum) : SINE_W'(sum);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [P_W-1:0]   p_s1;
	logic [T_W-1:0]   t_s1, t_s2, qc_s2;
	logic [Q_W-1:0]   q0_w, q0_s2, q_s3, q_s4, q_s5, ws_s5, r_w;
	logic [W_W-1:0]   w_s4;
	logic [Q_W+MS_W-1:0] wp_w;
	logic [W_W+SS_W-1:0] ws_w;
	logic [IDX_W-1:0] idx_s6;
	logic signed [SINE_W-1:0] sine_s7;

	assign q0_w = Q_W'(p_s1 >> Q_SHIFT);
	assign wp_w = q_s3 * MS_C;
	assign ws_w = w_s4 * SS_C;
	assign r_w  = q_s5 - ws_s5;

	// Quotient by reciprocal with one correction, then the remainder modulo the table size.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= dist_in * M_C;
			t_s1    <= dist_in * K_C;
			q0_s2   <= q0_w;
			qc_s2   <= q0_w * C_C;
			t_s2    <= t_s1;
			q_s3    <= q0_s2 + Q_W'((t_s2 - qc_s2) >= T_W'(C_C));
			w_s4    <= W_W'(wp_w >> W_SHIFT);
			q_s4    <= q_s3;
			ws_s5   <= Q_W'(ws_w);
			q_s5    <= q_s4;
			idx_s6  <= (r_w >= Q_W'(SS_C)) ? IDX_W'(r_w - Q_W'(SS_C)) : IDX_W'(r_w);
			sine_s7 <= SINE_ROM[idx_s6];
		end
	end

	assign sine = sine_s7;
endmodule

[sv/spp_back.sv]
// Pixel generator back: distances, sines, color fold; one pixel per clock unless stalled.
// Depends on spp_pkg, spp_if, spp_isqrt and spp_phase.
module spp_back import spp_pkg::*; #(
	parameter int MW         = PX_W,
	parameter int SINE_STEPS = SINE_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  logic [4*MW-1:0] q_data,
	output logic            pop,
	spp_color_if.source     color
);
	localparam int SQ_K  = MW + 7;
	localparam int SSQ_W = 2 * MW + 1;
	localparam int LAT   = 1 + SQ_K + PHASE_LAT + 1;
	localparam int PR_W  = SINE_W + 9;
	localparam int SUM_W = PR_W + 1;
	localparam int MAG_W = SUM_W - SUM_SHIFT;
	localparam int C_W   = MAG_W + 1;
	localparam logic signed [8:0] AMP1 = 9'(AMP_ONE);
	localparam logic signed [8:0] AMP2 = 9'(AMP_TWO);

	logic                     en;
	logic [LAT-1:0]           vld_q;
	logic                     out_vld_q;
	logic [COLOR_W-1:0]       color_q;
	logic [MW-1:0]            adx1, ady1, adx2, ady2;
	logic [SSQ_W-1:0]         ssq1_s1, ssq2_s1;
	logic [SQ_K-1:0]          root1, root2;
	logic [DIST_W-1:0]        d1, d2;
	logic signed [SINE_W-1:0] s1, s2;
	logic signed [PR_W-1:0]   m1_s2, m2_s2;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]         absv;
	logic [MAG_W-1:0]         mag;
	logic signed [C_W-1:0]    c;
	logic [COLOR_W-1:0]       cbyte;

	// The whole back advances together unless the output holds a result not yet taken.
	assign en  = !out_vld_q || color.ready;
	assign pop = en && q_valid;
	assign {adx1, ady1, adx2, ady2} = q_data;

	// Sums of squares.
	always_ff @(posedge clk) begin
		if (en) begin
			ssq1_s1 <= SSQ_W'(adx1 * adx1) + SSQ_W'(ady1 * ady1);
			ssq2_s1 <= SSQ_W'(adx2 * adx2) + SSQ_W'(ady2 * ady2);
		end
	end

	spp_isqrt #(.K(SQ_K)) u_sqrt1 (
		.clk(clk), .en(en), .rad({1'b0, ssq1_s1, DIST_FRAC2'(0)}), .root(root1)
	);
	spp_isqrt #(.K(SQ_K)) u_sqrt2 (
		.clk(clk), .en(en), .rad({1'b0, ssq2_s1, DIST_FRAC2'(0)}), .root(root2)
	);

	// Saturate the 10.6 distances.
	assign d1 = (root1 > SQ_K'(16'hffff)) ? 16'hffff : root1[DIST_W-1:0];
	assign d2 = (root2 > SQ_K'(16'hffff)) ? 16'hffff : root2[DIST_W-1:0];

	spp_phase #(.DIV(DIV_ONE), .SINE_STEPS(SINE_STEPS)) u_phase1 (
		.clk(clk), .en(en), .dist_in(d1), .sine(s1)
	);
	spp_phase #(.DIV(DIV_TWO), .SINE_STEPS(SINE_STEPS)) u_phase2 (
		.clk(clk), .en(en), .dist_in(d2), .sine(s2)
	);

	// Weighted sines.
	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2 <= s1 * AMP1;
			m2_s2 <= s2 * AMP2;
		end
	end

	// Truncate toward zero, fold above the limit, and keep the palette ends free.
	always_comb begin
		sum  = SUM_W'(m1_s2) + SUM_W'(m2_s2);
		absv = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		mag  = MAG_W'(absv >> SUM_SHIFT);
		c    = sum[SUM_W-1] ? -$signed(C_W'(mag)) : $signed(C_W'(mag));
		if (c > C_W'(FOLD_LIMIT)) begin
			c = C_W'(FOLD_BASE) - c;
		end
		cbyte = c[COLOR_W-1:0];
		if (cbyte == '0 || cbyte == COLOR_W'(FOLD_LIMIT)) begin
			cbyte = COLOR_W'(COLOR_SUB);
		end
	end

	// Valid tracking along the pipeline and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[LAT-2:0], q_valid};
			out_vld_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_q <= cbyte;
		end
	end

	assign color.valid       = out_vld_q;
	assign color.color_index = color_q;
endmodule

[verif/tb_sine_plasma_pixel_generator.sv]
// Self-checking testbench of the sine plasma pixel generator: random and directed
// pixels against a bit-exact color predictor, with random stalls on both channels.
// Depends on spp_pkg, spp_if and the block's RTL.
module tb_sine_plasma_pixel_generator;
	import spp_pkg::*;

	localparam int SCR_W = WIDTH_DEF;
	localparam int SCR_H = HEIGHT_DEF;
	localparam int STEPS = SINE_STEPS_DEF;
	localparam int LAT = 40;

	// Predicted color indexes, oldest first, and the predictor's own state.
	class color_scoreboard;
		bit [COLOR_W-1:0] pending_colors[$];
		int errors;
		int sine_lut[STEPS];
		int o1c, o1r, o2c, o2r;
		int vel[4];

		function new();
			longint unsigned f, u, x, x2, term;
			longint sum;
			int q;
			errors = 0;
			for (int k = 0; k < STEPS; k++) begin
				f = (longint'(k) << 32) / STEPS;
				q = int'((f >> 30) & 3);
				u = f & ((64'd1 << 30) - 1);
				if (q & 1) u = (64'd1 << 30) - u;
				x = (u * HALF_PI_Q30) >> 30;
				x2 = (x * x) >> 30;
				term = x;
				sum = longint'(x);
				for (int n = 1; n <= 7; n++) begin
					term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
					if (n & 1) sum -= longint'(term);
					else sum += longint'(term);
				end
				if (sum < 0) sum = 0;
				sum = (sum + 32768) >>> 16;
				sine_lut[k] = (q >= 2) ? -int'(sum) : int'(sum);
			end
		endfunction

		// Mirrors a register write into the predicted state.
		function void write_reg(cfg_reg_e idx, int value);
			logic signed [STEP_W-1:0] s;
			s = value[STEP_W-1:0];
			case (idx)
				REG_STEP_X_ONE: vel[0] = s;
				REG_STEP_Y_ONE: vel[1] = s;
				REG_STEP_X_TWO: vel[2] = s;
				REG_STEP_Y_TWO: vel[3] = s;
				REG_START_X_ONE: o1c = value & 511;
				REG_START_Y_ONE: o1r = value & 255;
				REG_START_X_TWO: o2c = value & 511;
				REG_START_Y_TWO: o2r = value & 255;
				default: ;
			endcase
		endfunction

		function void bounce_axis(ref int pos, ref int v, input int limit);
			logic signed [STEP_W-1:0] s;
			int p;
			p = pos + v;
			if (p > limit) begin
				s = -v;
				v = s;
				p = limit;
			end
			if (p < 1) begin
				s = -v;
				v = s;
				p = 1;
			end
			pos = p;
		endfunction

		function int unsigned distance(int px, int py, int ox, int oy);
			longint unsigned sq, r, b;
			sq = longint'((px - ox) * (px - ox) + (py - oy) * (py - oy)) << 12;
			r = 0;
			b = 64'd1 << 62;
			while (b > sq) b >>= 2;
			while (b != 0) begin
				if (sq >= r + b) begin
					sq -= r + b;
					r = (r >> 1) + b;
				end else r >>= 1;
				b >>= 2;
			end
			return (r > 65535) ? 65535 : int'(r);
		endfunction

		function int phase_sine(int unsigned d, int dv);
			longint unsigned idx;
			idx = (longint'(d) * STEPS * 65536) / (64 * dv * TWO_PI_Q16);
			return sine_lut[idx % STEPS];
		endfunction

		// Notes one accepted pixel and predicts its color.
		function void note_pixel(int px, int py, bit fs);
			int s1, s2, total, c;
			if (fs) begin
				bounce_axis(o1c, vel[0], SCR_W - 1);
				bounce_axis(o2c, vel[2], SCR_W - 1);
				bounce_axis(o1r, vel[1], SCR_H - 1);
				bounce_axis(o2r, vel[3], SCR_H - 1);
			end
			s1 = phase_sine(distance(px, py, o1c, o1r), DIV_ONE);
			s2 = phase_sine(distance(px, py, o2c, o2r), DIV_TWO);
			total = AMP_ONE * s1 + AMP_TWO * s2;
			c = (total < 0) ? -((-total) >>> SUM_SHIFT) : (total >>> SUM_SHIFT);
			if (c > FOLD_LIMIT) c = FOLD_BASE - c;
			c = c & 255;
			if (c == 0 || c == 255) c = COLOR_SUB;
			pending_colors.push_back(c[7:0]);
		endfunction

		function void check_color(bit [COLOR_W-1:0] got);
			bit [COLOR_W-1:0] want;
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected color %0d", $time, got);
				errors++;
				return;
			end
			want = pending_colors.pop_front();
			if (want !== got) begin
				$display("%0t: color_index expected %0d actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	int send_idle, recv_idle;
	color_scoreboard board;

	spp_pixel_if pix();
	spp_color_if color();
	spp_cfg_if cfg();

	sine_plasma_pixel_generator u_dut (
		.clk(clk), .arst_n(arst_n), .pix(pix.sink), .color(color.source), .cfg(cfg.sink)
	);

	always #6 clk = ~clk;

	// Random back-pressure on the color channel.
	always @(negedge clk) begin
		color.ready <= ($urandom_range(99) >= recv_idle);
	end

	// Checks every color transaction.
	always @(posedge clk) begin
		if (arst_n && color.valid && color.ready) board.check_color(color.color_index);
	end

	// One register write, after which valid drops on the configuration channel.
	task automatic write_reg(cfg_reg_e idx, int value);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, value);
		@(negedge clk);
		cfg.valid <= 0;
		@(negedge clk);
	endtask

	// Valid stays high after a transaction so that pixels can follow back to back.
	task automatic send_pixel(int px, int py, bit fs);
		while ($urandom_range(99) < send_idle) begin
			pix.valid <= 0;
			@(negedge clk);
		end
		pix.valid <= 1;
		pix.pixel_x <= px[PX_W-1:0];
		pix.pixel_y <= py[PY_W-1:0];
		pix.frame_start <= fs;
		do @(posedge clk); while (!pix.ready);
		board.note_pixel(px & 511, py & 255, fs);
		@(negedge clk);
	endtask

	task automatic drain();
		pix.valid <= 0;
		while (board.pending_colors.size() != 0) @(negedge clk);
		repeat (LAT) @(negedge clk);
	endtask

	task automatic write_all(int sx1, int sy1, int sx2, int sy2,
			int ax1, int ay1, int ax2, int ay2);
		write_reg(REG_STEP_X_ONE, sx1);
		write_reg(REG_STEP_Y_ONE, sy1);
		write_reg(REG_STEP_X_TWO, sx2);
		write_reg(REG_STEP_Y_TWO, sy2);
		write_reg(REG_START_X_ONE, ax1);
		write_reg(REG_START_Y_ONE, ay1);
		write_reg(REG_START_X_TWO, ax2);
		write_reg(REG_START_Y_TWO, ay2);
	endtask

	// A frame-start pixel, then pixels that may lie off-screen or start a frame.
	task automatic random_frames(int count);
		int n;
		n = 0;
		while (n < count) begin
			send_pixel($urandom_range(SCR_W - 1), $urandom_range(SCR_H - 1), 1);
			n++;
			repeat ($urandom_range(12)) begin
				if ($urandom_range(9) == 0)
					send_pixel($urandom_range(511), $urandom_range(255), $urandom_range(1));
				else
					send_pixel($urandom_range(SCR_W - 1), $urandom_range(SCR_H - 1), 0);
				n++;
			end
		end
	endtask

	initial begin
		#3000000;
		$display("FAIL sine_plasma_pixel_generator");
		$finish;
	end

	initial begin
		board = new();
		board.write_reg(REG_STEP_X_ONE, STEP_X_ONE_RST);
		board.write_reg(REG_STEP_Y_ONE, STEP_Y_ONE_RST);
		board.write_reg(REG_STEP_X_TWO, STEP_X_TWO_RST);
		board.write_reg(REG_STEP_Y_TWO, STEP_Y_TWO_RST);
		board.write_reg(REG_START_X_ONE, START_X_ONE_RST);
		board.write_reg(REG_START_Y_ONE, START_Y_ONE_RST);
		board.write_reg(REG_START_X_TWO, START_X_TWO_RST);
		board.write_reg(REG_START_Y_TWO, START_Y_TWO_RST);
		send_idle = 32;
		recv_idle = 49;
		pix.valid = 0;
		pix.pixel_x = 0;
		pix.pixel_y = 0;
		pix.frame_start = 0;
		color.ready = 0;
		cfg.valid = 0;
		cfg.index = REG_STEP_X_ONE;
		cfg.data = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: reset state, field extremes, off-screen pixels and frame starts.
		send_pixel(0, 0, 0);
		send_pixel(SCR_W - 1, SCR_H - 1, 0);
		send_pixel(511, 255, 0);
		send_pixel(100, 100, 0);
		send_pixel(42, 170, 1);
		drain();
		// Fast velocities against both edges, including the wrapping minus sixteen.
		write_all(8, -8, -16, 15, SCR_W - 1, 1, 1, SCR_H - 1);
		repeat (4) send_pixel(0, 0, 1);
		send_pixel(511, 0, 1);
		send_pixel(0, 255, 0);
		drain();
		// Origins off the screen are used until the next frame start.
		write_all(-8, 8, 0, -1, 511, 255, 0, 0);
		send_pixel(300, 10, 0);
		send_pixel(5, 190, 0);
		send_pixel(160, 100, 1);
		send_pixel(160, 100, 1);
		drain();
		write_all(2, -2, -3, 4, 100, 100, 42, 170);

		random_frames(270);
		drain();
		send_idle = 49;
		recv_idle = 32;
		write_all($urandom_range(16) - 8, $urandom_range(16) - 8, $urandom_range(16) - 8,
			$urandom_range(16) - 8, $urandom_range(SCR_W - 1, 1), $urandom_range(SCR_H - 1, 1),
			$urandom_range(SCR_W - 1, 1), $urandom_range(SCR_H - 1, 1));
		random_frames(270);
		drain();
		send_idle = 0;
		recv_idle = 0;
		write_all(-8, 8, 8, -8, 1, SCR_H - 1, SCR_W - 1, 1);
		random_frames(270);
		drain();

		if (board.errors == 0 && board.pending_colors.size() == 0)
			$display("PASS sine_plasma_pixel_generator");
		else
			$display("FAIL sine_plasma_pixel_generator");
		$finish;
	end
endmodule
